>>> hdl/hsvrgb_pkg.sv
// Shared constants, types and helpers for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 9;
    localparam int REM_BITS     = 6;
    localparam int SECTOR_DEG   = 60;
    localparam int FULL_TURN    = 360;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // full scale and the q/t denominator
    localparam longint unsigned FULL = (64'd1 << CHANNEL_BITS) - 64'd1;
    localparam longint unsigned DEN  = 64'(SECTOR_DEG) * FULL;
    localparam int DEN_BITS = $clog2(DEN + 1);

    // dividend widths; the reciprocal shift equals the dividend width
    localparam int XP_BITS = 2 * CHANNEL_BITS;
    localparam int XQ_BITS = CHANNEL_BITS + DEN_BITS;
    localparam int MP_BITS = XP_BITS - CHANNEL_BITS + 1;
    localparam int MQ_BITS = XQ_BITS - DEN_BITS + 1;
    localparam logic [MP_BITS-1:0] M_P = MP_BITS'((64'd1 << XP_BITS) / FULL);
    localparam logic [MQ_BITS-1:0] M_Q = MQ_BITS'((64'd1 << XQ_BITS) / DEN);

    localparam int IN_BITS        = HUE_BITS + 2 * CHANNEL_BITS;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = 3 * CHANNEL_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [REM_BITS-1:0]     rem_t;
    typedef logic [HUE_BITS-1:0]     hue_t;

    // hue sectors, 60 degrees each
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t sector;
        rem_t    rem;
        logic    gray;
        chan_t   sat;
        chan_t   val;
    } item_t;

    function automatic hue_t sector_base(sector_t s);
        hue_t b;
        case (s)
            SEC_RED_YEL: b = hue_t'(0);
            SEC_YEL_GRN: b = hue_t'(SECTOR_DEG);
            SEC_GRN_CYN: b = hue_t'(2 * SECTOR_DEG);
            SEC_CYN_BLU: b = hue_t'(3 * SECTOR_DEG);
            SEC_BLU_MAG: b = hue_t'(4 * SECTOR_DEG);
            SEC_MAG_RED: b = hue_t'(5 * SECTOR_DEG);
            default:     b = hue_t'(0);
        endcase
        return b;
    endfunction

endpackage

>>> hdl/hsvrgb_front.sv
// Front end: accepts a pixel, splits hue into sector and remainder, registers it.
module hsvrgb_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hsvrgb_pkg::IN_TDATA_BITS-1:0] s_tdata,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output hsvrgb_pkg::item_t                    out_item
);

    logic                 valid_reg;
    logic                 valid_next;
    hsvrgb_pkg::item_t    item_reg;
    hsvrgb_pkg::item_t    item_next;
    hsvrgb_pkg::hue_t     hue;
    hsvrgb_pkg::hue_t     hue_eff;
    hsvrgb_pkg::hue_t     rem_full;
    hsvrgb_pkg::sector_t  sector;

    assign hue = s_tdata[hsvrgb_pkg::HUE_BITS-1:0];

    always_comb
    begin
        // out-of-range hue folds to zero
        if (hue >= hsvrgb_pkg::hue_t'(hsvrgb_pkg::FULL_TURN))
        begin
            hue_eff = '0;
        end
        else
        begin
            hue_eff = hue;
        end

        if (hue_eff < hsvrgb_pkg::hue_t'(hsvrgb_pkg::SECTOR_DEG))
        begin
            sector = hsvrgb_pkg::SEC_RED_YEL;
        end
        else if (hue_eff < hsvrgb_pkg::hue_t'(2 * hsvrgb_pkg::SECTOR_DEG))
        begin
            sector = hsvrgb_pkg::SEC_YEL_GRN;
        end
        else if (hue_eff < hsvrgb_pkg::hue_t'(3 * hsvrgb_pkg::SECTOR_DEG))
        begin
            sector = hsvrgb_pkg::SEC_GRN_CYN;
        end
        else if (hue_eff < hsvrgb_pkg::hue_t'(4 * hsvrgb_pkg::SECTOR_DEG))
        begin
            sector = hsvrgb_pkg::SEC_CYN_BLU;
        end
        else if (hue_eff < hsvrgb_pkg::hue_t'(5 * hsvrgb_pkg::SECTOR_DEG))
        begin
            sector = hsvrgb_pkg::SEC_BLU_MAG;
        end
        else
        begin
            sector = hsvrgb_pkg::SEC_MAG_RED;
        end

        rem_full         = hue_eff - hsvrgb_pkg::sector_base(sector);
        item_next.sector = sector;
        item_next.rem    = rem_full[hsvrgb_pkg::REM_BITS-1:0];
        item_next.sat    = s_tdata[hsvrgb_pkg::HUE_BITS +: hsvrgb_pkg::CHANNEL_BITS];
        item_next.val    = s_tdata[hsvrgb_pkg::HUE_BITS + hsvrgb_pkg::CHANNEL_BITS +:
                                   hsvrgb_pkg::CHANNEL_BITS];
        item_next.gray   = (item_next.sat == '0);
    end

    assign s_tready   = !valid_reg || out_ready;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> item_reg.rem < hsvrgb_pkg::rem_t'(hsvrgb_pkg::SECTOR_DEG))
        else $error("front: remainder out of range");

endmodule

>>> hdl/hsvrgb_queue.sv
// Short queue between front end and arithmetic back end.
module hsvrgb_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hsvrgb_pkg::item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output hsvrgb_pkg::item_t out_item
);

    hsvrgb_pkg::item_t                  slot_reg [hsvrgb_pkg::QUEUE_DEPTH];
    logic [hsvrgb_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [hsvrgb_pkg::QPTR_BITS-1:0]   wr_ptr_next;
    logic [hsvrgb_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [hsvrgb_pkg::QPTR_BITS-1:0]   rd_ptr_next;
    logic [hsvrgb_pkg::QCNT_BITS-1:0]   count_reg;
    logic [hsvrgb_pkg::QCNT_BITS-1:0]   count_next;
    logic                               push;
    logic                               pop;

    assign in_ready  = (count_reg != hsvrgb_pkg::QCNT_BITS'(hsvrgb_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hsvrgb_pkg::QCNT_BITS'(hsvrgb_pkg::QUEUE_DEPTH))
        else $error("queue: fill count overflow");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue: push not counted");

endmodule

>>> hdl/hsvrgb_back.sv
// Back end: four-stage pipeline computing p, q, t and mapping them to RGB.
module hsvrgb_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  hsvrgb_pkg::item_t                     in_item,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [hsvrgb_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int CB  = hsvrgb_pkg::CHANNEL_BITS;
    localparam int DB  = hsvrgb_pkg::DEN_BITS;
    localparam int XPB = hsvrgb_pkg::XP_BITS;
    localparam int XQB = hsvrgb_pkg::XQ_BITS;
    localparam int PPB = hsvrgb_pkg::XP_BITS + hsvrgb_pkg::MP_BITS;
    localparam int PQB = hsvrgb_pkg::XQ_BITS + hsvrgb_pkg::MQ_BITS;
    localparam logic [CB-1:0]  FULL_C = CB'(hsvrgb_pkg::FULL);
    localparam logic [DB-1:0]  DEN_C  = DB'(hsvrgb_pkg::DEN);
    localparam logic [XPB-1:0] FULL_X = XPB'(hsvrgb_pkg::FULL);
    localparam logic [XQB-1:0] DEN_X  = XQB'(hsvrgb_pkg::DEN);

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    // per-stage carried fields
    hsvrgb_pkg::sector_t sec1_reg, sec2_reg, sec3_reg;
    logic                gray1_reg, gray2_reg, gray3_reg, gray4_reg;
    hsvrgb_pkg::chan_t   val1_reg, val2_reg, val3_reg;

    // stage 1: s*r, s*(60-r), v*(full-s)
    logic [DB-1:0]       srq1_reg, srt1_reg;
    logic [XPB-1:0]      xp1_reg, xp2_reg;
    hsvrgb_pkg::rem_t    rem_c;

    // stage 2: q/t dividends, p estimate
    logic [XQB-1:0]      xq2_reg, xt2_reg, xq3_reg, xt3_reg;
    logic [PPB-1:0]      prod_p;
    hsvrgb_pkg::chan_t   ep2_reg;

    // stage 3: q/t estimates, corrected p
    logic [PQB-1:0]      prod_q, prod_t;
    hsvrgb_pkg::chan_t   eq3_reg, et3_reg, p3_reg;
    logic [XPB-1:0]      rp;
    hsvrgb_pkg::chan_t   p_next;

    // stage 4: corrected q/t, channel select
    logic [XQB-1:0]      rq, rt;
    hsvrgb_pkg::chan_t   q_fin, t_fin;
    hsvrgb_pkg::chan_t   red_next, green_next, blue_next;
    hsvrgb_pkg::chan_t   red_reg, green_reg, blue_reg;

    assign ld4      = !v4_reg || m_tready;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign rem_c = hsvrgb_pkg::rem_t'(hsvrgb_pkg::SECTOR_DEG) - in_item.rem;

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            srq1_reg  <= DB'(in_item.sat) * DB'(in_item.rem);
            srt1_reg  <= DB'(in_item.sat) * DB'(rem_c);
            xp1_reg   <= XPB'(in_item.val) * XPB'(FULL_C - in_item.sat);
            sec1_reg  <= in_item.sector;
            gray1_reg <= in_item.gray;
            val1_reg  <= in_item.val;
        end
    end

    assign prod_p = PPB'(xp1_reg) * PPB'(hsvrgb_pkg::M_P);

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            xq2_reg   <= XQB'(val1_reg) * XQB'(DEN_C - srq1_reg);
            xt2_reg   <= XQB'(val1_reg) * XQB'(DEN_C - srt1_reg);
            ep2_reg   <= prod_p[XPB +: CB];
            xp2_reg   <= xp1_reg;
            sec2_reg  <= sec1_reg;
            gray2_reg <= gray1_reg;
            val2_reg  <= val1_reg;
        end
    end

    // reciprocal estimates are low by at most one; fix with one compare
    assign prod_q = PQB'(xq2_reg) * PQB'(hsvrgb_pkg::M_Q);
    assign prod_t = PQB'(xt2_reg) * PQB'(hsvrgb_pkg::M_Q);
    assign rp     = xp2_reg - XPB'(ep2_reg) * FULL_X;
    assign p_next = ep2_reg + CB'(rp >= FULL_X);

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            eq3_reg   <= prod_q[XQB +: CB];
            et3_reg   <= prod_t[XQB +: CB];
            p3_reg    <= p_next;
            xq3_reg   <= xq2_reg;
            xt3_reg   <= xt2_reg;
            sec3_reg  <= sec2_reg;
            gray3_reg <= gray2_reg;
            val3_reg  <= val2_reg;
        end
    end

    assign rq    = xq3_reg - XQB'(eq3_reg) * DEN_X;
    assign rt    = xt3_reg - XQB'(et3_reg) * DEN_X;
    assign q_fin = eq3_reg + CB'(rq >= DEN_X);
    assign t_fin = et3_reg + CB'(rt >= DEN_X);

    always_comb
    begin
        if (gray3_reg)
        begin
            red_next   = val3_reg;
            green_next = val3_reg;
            blue_next  = val3_reg;
        end
        else
        begin
            case (sec3_reg)
                hsvrgb_pkg::SEC_RED_YEL:
                begin
                    red_next = val3_reg; green_next = t_fin;    blue_next = p3_reg;
                end
                hsvrgb_pkg::SEC_YEL_GRN:
                begin
                    red_next = q_fin;    green_next = val3_reg; blue_next = p3_reg;
                end
                hsvrgb_pkg::SEC_GRN_CYN:
                begin
                    red_next = p3_reg;   green_next = val3_reg; blue_next = t_fin;
                end
                hsvrgb_pkg::SEC_CYN_BLU:
                begin
                    red_next = p3_reg;   green_next = q_fin;    blue_next = val3_reg;
                end
                hsvrgb_pkg::SEC_BLU_MAG:
                begin
                    red_next = t_fin;    green_next = p3_reg;   blue_next = val3_reg;
                end
                default:
                begin
                    red_next = val3_reg; green_next = p3_reg;   blue_next = q_fin;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4 && v3_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            gray4_reg <= gray3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = hsvrgb_pkg::OUT_TDATA_BITS'({blue_reg, green_reg, red_reg});

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && gray4_reg) |-> (red_reg == green_reg && green_reg == blue_reg))
        else $error("back: gray pixel with unequal channels");

    a_p_le_v: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (p3_reg <= val3_reg))
        else $error("back: p exceeds value");

endmodule

>>> hdl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter.
// Path: a result passes the front register, the queue write, then three arithmetic
//   stages and the output register.
// Throughput: one pixel per cycle, each stage and queue alike, unless output stalls.
// Reset (rst_n, async, active low) empties the front register, queue and pipeline;
//   the block takes a transfer on the first cycle after reset.
module hsv_to_rgb_converter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input pixel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata, lowest bit up: hue[8:0], saturation[16:9], brightness[24:17], zero pad
    input  logic [hsvrgb_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    // output pixel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata, lowest bit up: red[7:0], green[15:8], blue[23:16]
    output logic [hsvrgb_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    // front register -> queue
    logic              fq_valid;
    logic              fq_ready;
    hsvrgb_pkg::item_t fq_item;

    // queue -> arithmetic pipeline
    logic              qb_valid;
    logic              qb_ready;
    hsvrgb_pkg::item_t qb_item;

    // Front end: folds hue >= 360 to 0, picks the 60-degree sector and remainder,
    // flags zero saturation.
    hsvrgb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    // Queue decouples input acceptance from output back-pressure.
    hsvrgb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Back end: p, q, t via constant-reciprocal multiply with one correction step,
    // then the sector mapping into the output register.
    hsvrgb_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_item  (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> test/hsv_pixel_checker.sv
// Checker for the HSV to RGB converter: predicts each pixel and compares the output stream.
module hsv_pixel_checker
    import hsvrgb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_TDATA_BITS-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending_count,
    output int                        checked_count
);

    timeunit 1ns;
    timeprecision 1ps;

    // packed so that red sits in the low bits, as on m_tdata
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } rgb_t;

    rgb_t expected_rgb[$];

    function automatic rgb_t hsv_to_rgb(hue_t hue, chan_t sat, chan_t val);
        longint unsigned deg;
        longint unsigned frac;
        longint unsigned s;
        longint unsigned v;
        longint unsigned pv;
        longint unsigned qv;
        longint unsigned tv;
        sector_t         sec;
        rgb_t            c;
        deg = longint'(hue);
        s   = longint'(sat);
        v   = longint'(val);
        if (deg >= FULL_TURN)
            deg = 0;
        sec  = sector_t'(deg / SECTOR_DEG);
        frac = deg % SECTOR_DEG;
        pv = (v * (FULL - s)) / FULL;
        qv = (v * (DEN - s * frac)) / DEN;
        tv = (v * (DEN - s * (SECTOR_DEG - frac))) / DEN;
        if (sat == '0) begin
            c = '{blue: val, green: val, red: val};
        end
        else begin
            case (sec)
                SEC_RED_YEL: c = '{red: chan_t'(v),  green: chan_t'(tv), blue: chan_t'(pv)};
                SEC_YEL_GRN: c = '{red: chan_t'(qv), green: chan_t'(v),  blue: chan_t'(pv)};
                SEC_GRN_CYN: c = '{red: chan_t'(pv), green: chan_t'(v),  blue: chan_t'(tv)};
                SEC_CYN_BLU: c = '{red: chan_t'(pv), green: chan_t'(qv), blue: chan_t'(v)};
                SEC_BLU_MAG: c = '{red: chan_t'(tv), green: chan_t'(pv), blue: chan_t'(v)};
                default:     c = '{red: chan_t'(v),  green: chan_t'(pv), blue: chan_t'(qv)};
            endcase
        end
        return c;
    endfunction

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    always @(posedge clk)
    begin
        rgb_t want;
        rgb_t got;
        if (rst_n) begin
            // output side first: a pixel taken this edge can't leave on the same edge
            if (m_tvalid && m_tready) begin
                got = rgb_t'(m_tdata[OUT_BITS-1:0]);
                if (expected_rgb.size() == 0) begin
                    $error("unexpected output transfer: rgb 0x%06h", got);
                    fail_count++;
                end
                else begin
                    want = expected_rgb.pop_front();
                    checked_count++;
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_rgb.push_back(hsv_to_rgb(
                    s_tdata[HUE_BITS-1:0],
                    s_tdata[HUE_BITS +: CHANNEL_BITS],
                    s_tdata[HUE_BITS + CHANNEL_BITS +: CHANNEL_BITS]));
            pending_count = expected_rgb.size();
        end
    end

endmodule

>>> test/testbench.sv
// Top of the HSV to RGB converter test: clock, reset, pixel stimulus, output stalls, verdict.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    // cycles with no transfer on either side before the run is called hung;
    // the longest legal quiet spell is the receiver hold-off below
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 160;
    localparam int RANDOM_ITEMS = 1100;
    // give the block some margin after the last result
    localparam int DRAIN_CYCLES = 12;

    localparam int DIR_COUNT = 22;
    // directed pixels: every sector edge at full S/V, hue wrap, gray, black,
    // tiny and near-full fractions, and the top hue bit
    localparam int DIR_HUE[DIR_COUNT] = '{  0,  59,  60, 119, 120, 179, 180, 239,
                                          240, 299, 300, 359, 360, 511,  30, 200,
                                           90,  45, 150, 330, 270, 256};
    localparam int DIR_SAT[DIR_COUNT] = '{255, 255, 255, 255, 255, 255, 255, 255,
                                          255, 255, 255, 255, 255, 200,   0,   0,
                                            0, 255,   1, 128, 255, 170};
    localparam int DIR_VAL[DIR_COUNT] = '{255, 255, 255, 255, 255, 255, 255, 255,
                                          255, 255, 255, 255, 255, 180, 200,   0,
                                          255,   0, 255,  77,   1,  85};

    typedef enum int {
        RX_OPEN,    // always ready
        RX_CHOPPY,  // ready about half the time
        RX_SPARSE   // ready about a quarter of the time
    } rx_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   idle_cycles;
    int   burst_left;
    int   pixels_sent;
    int   wrapped_hues;
    int   gray_pixels;
    logic hold_request;
    logic hold_done;

    hsv_to_rgb_converter DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsv_pixel_checker pixel_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one pixel from the falling edge and hold it until the transfer.
    // valid is left high so back-to-back pixels go out with no gap between them.
    task automatic send_pixel(input int hue, input int sat, input int val);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_BITS'({chan_t'(val), chan_t'(sat), hue_t'(hue)});
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
        if (hue >= FULL_TURN)
            wrapped_hues++;
        if (sat == 0)
            gray_pixels++;
    endtask

    // Sender burst pacing: after a burst ends, drop valid for a random gap.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            // mostly short bursts, now and then a long unbroken run
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Random hue: mostly in range, some on sector edges, some past a full turn.
    function automatic int pick_hue();
        int pick;
        int h;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            h = $urandom_range(FULL_TURN, (1 << HUE_BITS) - 1);
        else if (pick < 20)
            h = SECTOR_DEG * $urandom_range(0, 5) + (($urandom_range(0, 1) == 1) ? 0 : 59);
        else
            h = $urandom_range(0, FULL_TURN - 1);
        return h;
    endfunction

    // Random channel fraction with its ends favored.
    function automatic int pick_fraction(input int zero_pct);
        int pick;
        int f;
        pick = $urandom_range(0, 99);
        if (pick < zero_pct)
            f = 0;
        else if (pick < zero_pct + 6)
            f = int'(FULL);
        else if (pick < zero_pct + 9)
            f = $urandom_range(1, 3);
        else
            f = $urandom_range(0, int'(FULL));
        return f;
    endfunction

    // Receiver: phases of random length and stall pattern, plus one long
    // hold-off on request so the queue and pipeline fill and s_tready drops.
    initial
    begin
        rx_mode_t mode;
        int       span;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
                hold_done = 1'b1;
            end
            mode = rx_mode_t'($urandom_range(0, 2));
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_CHOPPY: m_tready <= ($urandom_range(0, 1) == 1);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: a run with no transfer for too long is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_count);
            $display("hsv_to_rgb_converter test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        rst_n        = 1'b0;
        idle_cycles  = 0;
        burst_left   = 0;
        pixels_sent  = 0;
        wrapped_hues = 0;
        gray_pixels  = 0;
        hold_request = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        for (int i = 0; i < DIR_COUNT; i++)
        begin
            send_pixel(DIR_HUE[i], DIR_SAT[i], DIR_VAL[i]);
            pace_sender();
        end

        // random pixels; ask for the long output stall partway in
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 4)
                hold_request = 1'b1;
            send_pixel(pick_hue(), pick_fraction(8), pick_fraction(4));
            pace_sender();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels (%0d with hue past a full turn, %0d gray);",
                 pixels_sent, wrapped_hues, gray_pixels);
        $display("%0d results checked. Covered all six hue sectors and their edges,",
                 checked_count, " bursty input, and output stalls including one long hold-off.");
        if (fail_count == 0)
            $display("hsv_to_rgb_converter test passed");
        else
            $display("hsv_to_rgb_converter test failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_front.sv
hdl/hsvrgb_queue.sv
hdl/hsvrgb_back.sv
hdl/hsv_to_rgb_converter.sv
test/hsv_pixel_checker.sv
test/testbench.sv
